/* design/swfr_pkg.sv */
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared types and constants for the stop-and-wait frame receiver: line
// codes, reply codes, verdict codes and the beat formats between the parts.
// ----------------------------------------------------------------------------
package swfr_pkg;

    // Line codes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // Reply codes: RR with either ack; REJ is RR xor this mask
    localparam logic [7:0] ACK_EVEN  = 8'h01;
    localparam logic [7:0] ACK_ODD   = 8'h21;
    localparam logic [7:0] REJ_XOR   = 8'h04;

    // Expected sequence numbers in the control byte
    localparam logic [7:0] SEQ_EVEN  = 8'h00;
    localparam logic [7:0] SEQ_ODD   = 8'h02;

    // Verdict codes
    localparam logic [2:0] VERDICT_ACCEPTED  = 3'd0;
    localparam logic [2:0] VERDICT_DUPLICATE = 3'd1;
    localparam logic [2:0] VERDICT_REJECTED  = 3'd2;
    localparam logic [2:0] VERDICT_BAD_DUP   = 3'd3;
    localparam logic [2:0] VERDICT_HEADER    = 3'd4;
    localparam logic [2:0] VERDICT_TOO_LONG  = 3'd5;

    // Item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Defaults for top-level parameters
    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Field widths
    localparam int LENGTH_W = 11;
    localparam int REJECT_W = 16;

    // Destuffed token from the front part
    typedef struct packed {
        logic       is_flag;  // closing/opening flag
        logic       esc;      // escape was pending when the flag arrived
        logic [7:0] data;     // destuffed byte when not a flag
    } token_t;

    // One result item
    typedef struct packed {
        logic                item_kind;
        logic [7:0]          payload_byte;
        logic [2:0]          verdict;
        logic                reply_valid;
        logic [7:0]          reply_control;
        logic [LENGTH_W-1:0] payload_length;
        logic [REJECT_W-1:0] reject_total;
    } result_t;

endpackage

/* design/swfr_front.sv */
// ----------------------------------------------------------------------------
// swfr_front
// Takes raw line bytes, strips escapes and classifies each byte as a flag
// token or a data token for the queue.
// ----------------------------------------------------------------------------
module swfr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 q_full,
    output logic                 push,
    output swfr_pkg::token_t     push_token
);

    logic escape_reg;
    logic escape_next;
    logic beat;

    assign s_tready = !q_full;
    assign beat     = s_tvalid && s_tready;

    // Classify the beat and track a pending escape
    always_comb begin
        escape_next        = escape_reg;
        push               = 1'b0;
        push_token.is_flag = 1'b0;
        push_token.esc     = 1'b0;
        push_token.data    = s_tdata;
        if (beat) begin
            if (s_tdata == swfr_pkg::FLAG_BYTE) begin
                push               = 1'b1;
                push_token.is_flag = 1'b1;
                push_token.esc     = escape_reg;
                escape_next        = 1'b0;
            end else if (escape_reg) begin
                push            = 1'b1;
                push_token.data = s_tdata ^ swfr_pkg::ESC_XOR;
                escape_next     = 1'b0;
            end else if (s_tdata == swfr_pkg::ESC_BYTE) begin
                escape_next = 1'b1;
            end else begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg <= 1'b0;
        end else begin
            escape_reg <= escape_next;
        end
    end

endmodule

/* design/swfr_queue.sv */
// ----------------------------------------------------------------------------
// swfr_queue
// Short token queue between the front and back parts.
// ----------------------------------------------------------------------------
module swfr_queue #(
    parameter int DEPTH = swfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  swfr_pkg::token_t  push_token,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop,
    output swfr_pkg::token_t  pop_token
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    swfr_pkg::token_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_token = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the token
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

/* design/swfr_back.sv */
// ----------------------------------------------------------------------------
// swfr_back
// Frame state machine: checks the header, holds back one data byte, releases
// payload, and gives the end-of-frame verdict through an output register.
// ----------------------------------------------------------------------------
module swfr_back #(
    parameter int MAX_PAYLOAD = swfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tok_valid,
    output logic              tok_ready,
    input  swfr_pkg::token_t  tok,
    output logic              m_valid,
    input  logic              m_ready,
    output swfr_pkg::result_t m_result
);

    localparam int CNT_W = ($clog2(MAX_PAYLOAD + 1) > swfr_pkg::LENGTH_W)
                           ? $clog2(MAX_PAYLOAD + 1) : swfr_pkg::LENGTH_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);
    localparam int RW = swfr_pkg::REJECT_W;

    // Frame phases
    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_ADDR   = 3'd1;
    localparam logic [2:0] PH_CTRL   = 3'd2;
    localparam logic [2:0] PH_BCC1   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_BADHDR = 3'd5;
    localparam logic [2:0] PH_LONG   = 3'd6;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       ctrl_reg, ctrl_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ack_reg, ack_next;
    logic [RW-1:0]    rej_reg, rej_next;
    logic             out_valid_reg, out_valid_next;
    swfr_pkg::result_t out_reg, out_next;

    logic             take;
    logic             emit;
    logic             bad;
    logic             is_new;
    logic [7:0]       ack_code;
    logic [7:0]       new_ack_code;
    logic [7:0]       expected;
    logic [RW-1:0]    rej_inc;
    logic [CNT_W-1:0] count_inc;

    assign tok_ready = !out_valid_reg || m_ready;
    assign take      = tok_valid && tok_ready;
    assign m_valid   = out_valid_reg;
    assign m_result  = out_reg;

    assign ack_code     = ack_reg ? swfr_pkg::ACK_ODD : swfr_pkg::ACK_EVEN;
    assign new_ack_code = ack_reg ? swfr_pkg::ACK_EVEN : swfr_pkg::ACK_ODD;
    assign expected     = ack_reg ? swfr_pkg::SEQ_ODD : swfr_pkg::SEQ_EVEN;
    assign is_new       = (ctrl_reg == expected);
    assign bad          = !held_valid_reg || tok.esc || (xor_reg != held_reg);
    assign rej_inc      = (rej_reg != {RW{1'b1}}) ? rej_reg + 1'b1 : rej_reg;
    assign count_inc    = count_reg + 1'b1;

    // Advance the frame state on each token
    always_comb begin
        phase_next      = phase_reg;
        addr_next       = addr_reg;
        ctrl_next       = ctrl_reg;
        xor_next        = xor_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        ack_next        = ack_reg;
        rej_next        = rej_reg;
        emit            = 1'b0;

        out_next.item_kind      = swfr_pkg::KIND_VERDICT;
        out_next.payload_byte   = 8'h00;
        out_next.verdict        = swfr_pkg::VERDICT_ACCEPTED;
        out_next.reply_valid    = 1'b0;
        out_next.reply_control  = 8'h00;
        out_next.payload_length = count_reg[swfr_pkg::LENGTH_W-1:0];
        out_next.reject_total   = rej_reg;

        if (take) begin
            if (tok.is_flag) begin
                emit = 1'b1;
                case (phase_reg)
                    PH_CTRL, PH_BCC1, PH_BADHDR: begin
                        out_next.verdict = swfr_pkg::VERDICT_HEADER;
                    end
                    PH_LONG: begin
                        out_next.verdict = swfr_pkg::VERDICT_TOO_LONG;
                    end
                    PH_DATA: begin
                        out_next.reply_valid = 1'b1;
                        if (!bad && is_new) begin
                            ack_next               = !ack_reg;
                            out_next.verdict       = swfr_pkg::VERDICT_ACCEPTED;
                            out_next.reply_control = new_ack_code;
                        end else if (!bad) begin
                            out_next.verdict       = swfr_pkg::VERDICT_DUPLICATE;
                            out_next.reply_control = ack_code;
                        end else if (is_new) begin
                            rej_next               = rej_inc;
                            out_next.verdict       = swfr_pkg::VERDICT_REJECTED;
                            out_next.reply_control = ack_code ^ swfr_pkg::REJ_XOR;
                            out_next.reject_total  = rej_inc;
                        end else begin
                            out_next.verdict       = swfr_pkg::VERDICT_BAD_DUP;
                            out_next.reply_control = ack_code;
                        end
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
                // Open a fresh frame
                phase_next      = PH_ADDR;
                addr_next       = 8'h00;
                ctrl_next       = 8'h00;
                xor_next        = 8'h00;
                held_next       = 8'h00;
                held_valid_next = 1'b0;
                count_next      = '0;
            end else begin
                case (phase_reg)
                    PH_ADDR: begin
                        addr_next  = tok.data;
                        phase_next = PH_CTRL;
                    end
                    PH_CTRL: begin
                        ctrl_next  = tok.data;
                        phase_next = PH_BCC1;
                    end
                    PH_BCC1: begin
                        phase_next = ((addr_reg ^ ctrl_reg) == tok.data) ? PH_DATA : PH_BADHDR;
                    end
                    PH_DATA: begin
                        if (!held_valid_reg) begin
                            held_next       = tok.data;
                            held_valid_next = 1'b1;
                        end else if (count_reg >= MAX_CNT) begin
                            phase_next = PH_LONG;
                        end else begin
                            // Release the held byte, hold the new one
                            emit                    = 1'b1;
                            xor_next                = xor_reg ^ held_reg;
                            count_next              = count_inc;
                            held_next               = tok.data;
                            out_next.item_kind      = swfr_pkg::KIND_PAYLOAD;
                            out_next.payload_byte   = held_reg;
                            out_next.payload_length = count_inc[swfr_pkg::LENGTH_W-1:0];
                        end
                    end
                    default: begin
                        // drop bytes while hunting or discarding
                    end
                endcase
            end
        end

        // Output register: load, drain or hold
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            addr_reg       <= 8'h00;
            ctrl_reg       <= 8'h00;
            xor_reg        <= 8'h00;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            ack_reg        <= 1'b0;
            rej_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            addr_reg       <= addr_next;
            ctrl_reg       <= ctrl_next;
            xor_reg        <= xor_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
            ack_reg        <= ack_next;
            rej_reg        <= rej_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= out_next;
        end
    end

endmodule

/* design/stop_and_wait_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver_core
// Receives line bytes, removes escapes, checks frames and releases payload
// bytes and end-of-frame verdicts with the RR/REJ reply code.
//
//   channel | dir | beat carries
//   s_      | in  | one raw line byte
//   m_      | out | payload byte (tuser 0) or frame verdict (tuser 1)
//
// One line byte is taken per cycle while the token queue is not full. The
// byte is written to a queue slot at the edge that takes it; the back part
// then pops the token and, when it yields a result, loads the output register
// that drives m_tvalid. The front part stalls only when the token queue is
// full; the back part stalls only while its output register holds a result
// not yet taken. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module stop_and_wait_frame_receiver_core #(
    parameter int MAX_PAYLOAD = swfr_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = swfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] payload_byte, [10:8] verdict,
                                   // [11] reply_valid, [19:12] reply_control,
                                   // [30:20] payload_length, [46:31] reject_total
    output logic        m_tuser    // [0] item_kind
);

    logic              q_full;
    logic              push;
    swfr_pkg::token_t  push_token;
    logic              pop_valid;
    logic              pop;
    swfr_pkg::token_t  pop_token;
    swfr_pkg::result_t result;

    swfr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_token (push_token)
    );

    swfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_token (push_token),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_token  (pop_token)
    );

    swfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (pop_valid),
        .tok_ready (pop),
        .tok       (pop_token),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (result)
    );

    // Pack the result beat
    assign m_tuser = result.item_kind;
    assign m_tdata = {1'b0,
                      result.reject_total,
                      result.payload_length,
                      result.reply_control,
                      result.reply_valid,
                      result.verdict,
                      result.payload_byte};

endmodule

/* test/tb_stop_and_wait_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// tb_stop_and_wait_frame_receiver_core
// Self-checking bench for the stop-and-wait frame receiver. Line bytes go in
// on the s_ stream. A scoreboard predicts every payload beat and every frame
// verdict and compares each result beat with the oldest prediction, field by
// field. Stimulus: a short directed run, then random stuffed frames with
// broken ones mixed in. Both sides idle at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_frame_receiver_core;

    localparam int PAYLOAD_LIMIT = swfr_pkg::MAX_PAYLOAD_DEF;
    localparam int RANDOM_BYTES  = 575;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [2:0] {
        PH_HUNT, PH_ADDR, PH_CTRL, PH_BCC1, PH_DATA, PH_BADHDR, PH_LONG
    } rx_phase_t;

    // Predicts the result beats caused by each line byte and checks them
    class frame_rx_scoreboard;
        rx_phase_t         phase;
        logic              esc_pending;
        logic [7:0]        addr_q;
        logic [7:0]        ctrl_q;
        logic [7:0]        run_xor;
        logic [7:0]        held_q;
        logic              held_ok;
        int unsigned       released;
        logic              ack_odd;
        int unsigned       rej_count;
        swfr_pkg::result_t expected_items[$];
        int unsigned       failures;

        function new();
            phase     = PH_HUNT;
            ack_odd   = 1'b0;
            rej_count = 0;
            failures  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            esc_pending = 1'b0;
            addr_q      = '0;
            ctrl_q      = '0;
            run_xor     = '0;
            held_q      = '0;
            held_ok     = 1'b0;
            released    = 0;
        endfunction

        function logic [7:0] ack_code();
            return ack_odd ? swfr_pkg::ACK_ODD : swfr_pkg::ACK_EVEN;
        endfunction

        function void push_verdict(logic [2:0] v, logic rv, logic [7:0] rc);
            swfr_pkg::result_t r;
            r                = '0;
            r.item_kind      = swfr_pkg::KIND_VERDICT;
            r.verdict        = v;
            r.reply_valid    = rv;
            r.reply_control  = rc;
            r.payload_length = released[swfr_pkg::LENGTH_W-1:0];
            r.reject_total   = rej_count[swfr_pkg::REJECT_W-1:0];
            expected_items.push_back(r);
        endfunction

        // Judge a data frame at its closing flag
        function void close_data_frame();
            logic bad;
            logic is_new;
            bad    = !held_ok || esc_pending || (run_xor != held_q);
            is_new = (ctrl_q == (ack_odd ? swfr_pkg::SEQ_ODD : swfr_pkg::SEQ_EVEN));
            if (!bad && is_new) begin
                ack_odd = ~ack_odd;
                push_verdict(swfr_pkg::VERDICT_ACCEPTED, 1'b1, ack_code());
            end else if (!bad) begin
                push_verdict(swfr_pkg::VERDICT_DUPLICATE, 1'b1, ack_code());
            end else if (is_new) begin
                if (rej_count < 16'hFFFF)
                    rej_count++;
                push_verdict(swfr_pkg::VERDICT_REJECTED, 1'b1,
                             ack_code() ^ swfr_pkg::REJ_XOR);
            end else begin
                push_verdict(swfr_pkg::VERDICT_BAD_DUP, 1'b1, ack_code());
            end
        endfunction

        // Advance the prediction by one accepted line byte
        function void note_line_byte(logic [7:0] raw);
            logic [7:0]        b;
            swfr_pkg::result_t r;
            b = raw;
            if (raw == swfr_pkg::FLAG_BYTE) begin
                case (phase)
                    PH_CTRL, PH_BCC1, PH_BADHDR: begin
                        push_verdict(swfr_pkg::VERDICT_HEADER, 1'b0, 8'h00);
                    end
                    PH_LONG: begin
                        push_verdict(swfr_pkg::VERDICT_TOO_LONG, 1'b0, 8'h00);
                    end
                    PH_DATA: close_data_frame();
                    default: ;
                endcase
                phase = PH_ADDR;
                clear_frame();
                return;
            end
            if (phase == PH_HUNT || phase == PH_BADHDR || phase == PH_LONG)
                return;

            // Remove escapes
            if (esc_pending) begin
                b = b ^ swfr_pkg::ESC_XOR;
                esc_pending = 1'b0;
            end else if (b == swfr_pkg::ESC_BYTE) begin
                esc_pending = 1'b1;
                return;
            end

            case (phase)
                PH_ADDR: begin
                    addr_q = b;
                    phase  = PH_CTRL;
                    return;
                end
                PH_CTRL: begin
                    ctrl_q = b;
                    phase  = PH_BCC1;
                    return;
                end
                PH_BCC1: begin
                    phase = ((addr_q ^ ctrl_q) == b) ? PH_DATA : PH_BADHDR;
                    return;
                end
                default: ;
            endcase

            // Hold data back one place so the check byte is never released
            if (!held_ok) begin
                held_q  = b;
                held_ok = 1'b1;
                return;
            end
            if (released >= PAYLOAD_LIMIT) begin
                phase = PH_LONG;
                return;
            end
            run_xor  = run_xor ^ held_q;
            released++;
            r                = '0;
            r.item_kind      = swfr_pkg::KIND_PAYLOAD;
            r.payload_byte   = held_q;
            r.payload_length = released[swfr_pkg::LENGTH_W-1:0];
            r.reject_total   = rej_count[swfr_pkg::REJECT_W-1:0];
            expected_items.push_back(r);
            held_q = b;
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_beat(logic [47:0] data, logic kind);
            swfr_pkg::result_t e;
            if (expected_items.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result beat: kind %0d data %012h", kind, data);
                return;
            end
            e = expected_items.pop_front();
            if (kind !== e.item_kind || data[7:0] !== e.payload_byte ||
                data[10:8] !== e.verdict || data[11] !== e.reply_valid ||
                data[19:12] !== e.reply_control ||
                data[30:20] !== e.payload_length ||
                data[46:31] !== e.reject_total) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display({"mismatch: expected kind %0d byte %02h verdict %0d ",
                              "reply %0d/%02h len %0d rej %0d"},
                             e.item_kind, e.payload_byte, e.verdict, e.reply_valid,
                             e.reply_control, e.payload_length, e.reject_total);
                    $display({"          actual   kind %0d byte %02h verdict %0d ",
                              "reply %0d/%02h len %0d rej %0d"},
                             kind, data[7:0], data[10:8], data[11], data[19:12],
                             data[30:20], data[46:31]);
                end
            end
        endfunction

        function int pending();
            return expected_items.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    frame_rx_scoreboard board = new();

    int unsigned bytes_sent = 0;
    logic        sender_burst = 1'b0;
    logic        hold_off = 1'b0;
    int unsigned cycles = 0;

    stop_and_wait_frame_receiver_core #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one line byte, idling first unless in a burst
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        board.note_line_byte(b);
        bytes_sent++;
    endtask

    // Send one frame byte, escaping codes and now and then a plain byte
    task automatic send_stuffed(input logic [7:0] b);
        if (b == swfr_pkg::FLAG_BYTE || b == swfr_pkg::ESC_BYTE ||
            ($urandom_range(0, 15) == 0 &&
             (b ^ swfr_pkg::ESC_XOR) != swfr_pkg::FLAG_BYTE)) begin
            send_byte(swfr_pkg::ESC_BYTE);
            send_byte(b ^ swfr_pkg::ESC_XOR);
        end else begin
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0: return swfr_pkg::FLAG_BYTE;
            1: return swfr_pkg::ESC_BYTE;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_ctrl();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return swfr_pkg::SEQ_EVEN;
        else if (r < 8)
            return swfr_pkg::SEQ_ODD;
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one random frame; most are well formed, some broken on purpose
    task automatic send_random_frame();
        logic [7:0] a;
        logic [7:0] c;
        logic [7:0] h;
        logic [7:0] d;
        logic [7:0] x;
        int         sel;
        int         n;
        sender_burst = ($urandom_range(0, 4) == 0);
        sel = $urandom_range(0, 19);
        if ($urandom_range(0, 1) == 1)
            send_byte(swfr_pkg::FLAG_BYTE);
        a = 8'($urandom_range(0, 255));
        c = pick_ctrl();

        // Cut the header short
        if (sel == 0) begin
            send_stuffed(a);
            if ($urandom_range(0, 1) == 1)
                send_stuffed(c);
            send_byte(swfr_pkg::FLAG_BYTE);
            return;
        end

        // Garbage between flags
        if (sel == 4) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)));
            send_byte(swfr_pkg::FLAG_BYTE);
            return;
        end

        h = a ^ c;
        if (sel == 5)
            h = h ^ 8'($urandom_range(1, 255));
        send_stuffed(a);
        send_stuffed(c);
        send_stuffed(h);

        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 14);
        x = '0;
        for (int i = 0; i < n; i++) begin
            d = pick_data();
            x = x ^ d;
            send_stuffed(d);
        end

        // Check byte: missing, corrupted or right
        if (sel != 1) begin
            if (sel == 2)
                x = x ^ 8'($urandom_range(1, 255));
            send_stuffed(x);
        end
        if (sel == 3)
            send_byte(swfr_pkg::ESC_BYTE);
        send_byte(swfr_pkg::FLAG_BYTE);
    endtask

    // Stimulus, then drain and report
    initial begin
        logic [7:0]  opening_run[$];
        int unsigned random_start;
        opening_run = '{8'h55, swfr_pkg::FLAG_BYTE, swfr_pkg::FLAG_BYTE,
                        8'h03, swfr_pkg::SEQ_EVEN, 8'h03, swfr_pkg::ESC_BYTE,
                        8'h5E, 8'hFF, 8'h81, swfr_pkg::FLAG_BYTE,
                        8'h03, swfr_pkg::SEQ_EVEN, 8'h03, swfr_pkg::FLAG_BYTE,
                        8'h03, swfr_pkg::FLAG_BYTE,
                        8'h03, swfr_pkg::SEQ_ODD, 8'h00, swfr_pkg::FLAG_BYTE,
                        8'hFF, swfr_pkg::SEQ_ODD, 8'hFD, swfr_pkg::ESC_BYTE,
                        swfr_pkg::FLAG_BYTE};
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_run[i])
            send_byte(opening_run[i]);

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
            send_random_frame();
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("stop_and_wait_frame_receiver_core test passed");
        end else begin
            $display("stop_and_wait_frame_receiver_core test failed");
        end
        $finish;
    end

    // Take result beats with random stalls and occasional no-stall runs
    initial begin
        int stall;
        int burst_left;
        burst_left = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (burst_left > 0) begin
                stall = 0;
                burst_left--;
            end else begin
                stall = $urandom_range(0, 4);
                if ($urandom_range(0, 15) == 0)
                    burst_left = $urandom_range(10, 40);
            end
            if (stall > 0 || hold_off) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                while (hold_off)
                    @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_beat(m_tdata, m_tuser);
        end
    end

    // Hold off the receiver long enough for the block to back up
    initial begin
        do @(posedge aclk); while (!aresetn);
        repeat (400) @(posedge aclk);
        hold_off = 1'b1;
        repeat (300) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Abort a hung run
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("stop_and_wait_frame_receiver_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
design/swfr_pkg.sv
design/swfr_front.sv
design/swfr_queue.sv
design/swfr_back.sv
design/stop_and_wait_frame_receiver_core.sv
test/tb_stop_and_wait_frame_receiver_core.sv
